FILE: rtl/core/shift_jis_to_iso2022_jp_top_defines.svh
// ----------------------------------------------------------------------------
// shift_jis_to_iso2022_jp_top_defines.svh
// assertion macros shared by the converter modules
// ----------------------------------------------------------------------------
`ifndef SHIFT_JIS_TO_ISO2022_JP_TOP_DEFINES_SVH
`define SHIFT_JIS_TO_ISO2022_JP_TOP_DEFINES_SVH

// checked only outside reset
`define SJTIJ_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// checked at every edge, reset included
`define SJTIJ_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

FILE: rtl/core/sjtij_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sjtij_pkg
// types, escape bytes and code helpers for the shift-jis to iso-2022-jp converter
// ----------------------------------------------------------------------------
package sjtij_pkg;

   localparam int BurstDepth = 8;
   localparam int CountWidth = $clog2(BurstDepth + 1);
   localparam int IndexWidth = $clog2(BurstDepth);

   localparam logic [7:0] ESC_BYTE       = 8'h1B;
   localparam logic [7:0] ENTER_MID_BYTE = 8'h24;
   localparam logic [7:0] LEAVE_MID_BYTE = 8'h28;
   localparam logic [7:0] FINAL_BYTE     = 8'h42;

   typedef struct packed {
      logic [7:0] in_byte;
      logic       in_last;
   } req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       out_last;
   } rsp_type;

   // one request's worth of output bytes, slot 0 goes out first
   typedef struct packed {
      logic [CountWidth-1:0]           count;
      logic [BurstDepth-1:0][7:0]      bytes;
   } burst_type;

   function automatic logic is_lead(input logic [7:0] b);
      return ((b >= 8'h81) && (b <= 8'h9F)) || ((b >= 8'hE0) && (b <= 8'hFC));
   endfunction

   function automatic logic is_trail(input logic [7:0] b);
      return ((b >= 8'h40) && (b <= 8'h7E)) || ((b >= 8'h80) && (b <= 8'hFC));
   endfunction

   // returns {row, cell}; leads from 0xf0 up are outside the table
   function automatic logic [15:0] sjis_to_jis(input logic [7:0] lead,
                                               input logic [7:0] trail);
      logic [7:0] h;
      logic [7:0] l;
      h = lead;
      l = trail;
      if (lead >= 8'hF0) begin
         return 16'h0000;
      end
      if (h >= 8'hE0) begin
         h = h - 8'h40;
      end
      h = ((h - 8'h81) << 1) + 8'h21;
      if (l > 8'h7F) begin
         l = l - 8'h01;
      end
      if (l > 8'h9D) begin
         h = h + 8'h01;
         l = l - 8'h7D;
      end else begin
         l = l - 8'h1F;
      end
      return {h, l};
   endfunction

endpackage

FILE: rtl/core/shift_jis_to_iso2022_jp_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// shift_jis_to_iso2022_jp_top
// shift-jis byte stream in, iso-2022-jp byte stream out, escapes inserted
// ----------------------------------------------------------------------------
//  channel   direction   payload                     handshake
//  req_      in          in_byte[7:0], in_last       req_valid / req_ready
//  rsp_      out         out_byte[7:0], out_last     rsp_valid / rsp_ready
//
//  a request is taken every cycle while the output is free; its zero to eight
//  output bytes then leave at one byte per cycle from the burst register while
//  rsp_ready is high; a lead byte held for its trail gives no output; requests
//  go through the input register, then the burst register; a stalled rsp_
//  receiver holds the burst and one waiting request, then req_ready drops
//  synchronous reset returns to single-byte mode with no lead held
// ----------------------------------------------------------------------------
module shift_jis_to_iso2022_jp_top (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  sjtij_pkg::req_type req_data,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output sjtij_pkg::rsp_type rsp_data
);
   import sjtij_pkg::*;

   logic      cur_valid;
   req_type   cur_req;
   burst_type burst;
   logic      can_load;
   logic      advance;
   logic      load;

   // requests with nothing to send move on even while a burst is draining
   assign advance = cur_valid && ((burst.count == '0) || can_load);
   assign load    = advance && (burst.count != '0);

   sjtij_input_reg u_input_reg (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .advance    (advance),
      .held_valid (cur_valid),
      .held_data  (cur_req)
   );

   sjtij_encoder u_encoder (
      .clock   (clock),
      .reset   (reset),
      .cur_req (cur_req),
      .advance (advance),
      .burst   (burst)
   );

   sjtij_serializer u_serializer (
      .clock     (clock),
      .reset     (reset),
      .load      (load),
      .burst     (burst),
      .can_load  (can_load),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

FILE: rtl/core/sjtij_input_reg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sjtij_input_reg
// request register in front of the encoder
// ----------------------------------------------------------------------------
module sjtij_input_reg (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  sjtij_pkg::req_type req_data,
   input  logic              advance,
   output logic              held_valid,
   output sjtij_pkg::req_type held_data
);
   import sjtij_pkg::*;

   logic    valid_ff;
   logic    valid_in;
   req_type data_ff;
   req_type data_in;

   assign req_ready = !valid_ff || advance;

   always_comb begin
      valid_in = valid_ff;
      data_in  = data_ff;
      if (req_valid && req_ready) begin
         valid_in = 1'b1;
         data_in  = req_data;
      end else if (advance) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign held_valid = valid_ff;
   assign held_data  = data_ff;

endmodule

FILE: rtl/core/sjtij_encoder.sv
`timescale 1ns / 1ps
`include "shift_jis_to_iso2022_jp_top_defines.svh"
// ----------------------------------------------------------------------------
// sjtij_encoder
// mode tracking and output burst assembly for one request
// ----------------------------------------------------------------------------
module sjtij_encoder (
   input  logic                 clock,
   input  logic                 reset,
   input  sjtij_pkg::req_type   cur_req,
   input  logic                 advance,
   output sjtij_pkg::burst_type burst
);
   import sjtij_pkg::*;

   logic       kanji_ff;
   logic       kanji_in;
   logic       held_ff;
   logic       held_in;
   logic [7:0] lead_ff;
   logic [7:0] lead_in;

   logic       b_lead;
   logic       b_trail;
   logic       hold_new;
   logic       pair;
   logic       esc_enter;
   logic       esc_leave;
   logic       tail_leave;
   logic [1:0] num_payload;
   logic [7:0] pay0;
   logic [7:0] pay1;
   logic [15:0] jis;
   logic [CountWidth-1:0] pos;
   logic [BurstDepth-1:0][7:0] slots;

   assign b_lead   = is_lead(cur_req.in_byte);
   assign b_trail  = is_trail(cur_req.in_byte);
   assign pair     = held_ff && b_trail;
   assign hold_new = b_lead && !cur_req.in_last && !pair;
   assign jis      = sjis_to_jis(lead_ff, cur_req.in_byte);

   always_comb begin
      esc_enter   = pair && !kanji_ff;
      esc_leave   = !pair && kanji_ff && (held_ff || !hold_new);
      tail_leave  = pair && cur_req.in_last;
      num_payload = 2'd0;
      pay0        = cur_req.in_byte;
      pay1        = cur_req.in_byte;
      if (pair) begin
         num_payload = 2'd2;
         pay0        = jis[15:8];
         pay1        = jis[7:0];
      end else if (held_ff) begin
         // held lead with no trail goes out alone, then the new byte unless held
         pay0        = lead_ff;
         num_payload = hold_new ? 2'd1 : 2'd2;
      end else if (!hold_new) begin
         num_payload = 2'd1;
      end
   end

   always_comb begin
      slots = '0;
      pos   = '0;
      if (esc_enter || esc_leave) begin
         slots[0] = ESC_BYTE;
         slots[1] = esc_enter ? ENTER_MID_BYTE : LEAVE_MID_BYTE;
         slots[2] = FINAL_BYTE;
         pos      = CountWidth'(3);
      end
      if (num_payload != 2'd0) begin
         slots[pos[IndexWidth-1:0]] = pay0;
         pos = pos + CountWidth'(1);
      end
      if (num_payload == 2'd2) begin
         slots[pos[IndexWidth-1:0]] = pay1;
         pos = pos + CountWidth'(1);
      end
      if (tail_leave) begin
         slots[pos[IndexWidth-1:0]]                        = ESC_BYTE;
         slots[IndexWidth'(pos[IndexWidth-1:0] + 3'd1)]    = LEAVE_MID_BYTE;
         slots[IndexWidth'(pos[IndexWidth-1:0] + 3'd2)]    = FINAL_BYTE;
         pos = pos + CountWidth'(3);
      end
      burst.count = pos;
      burst.bytes = slots;
   end

   always_comb begin
      kanji_in = kanji_ff;
      held_in  = held_ff;
      lead_in  = lead_ff;
      if (advance) begin
         held_in = hold_new;
         lead_in = hold_new ? cur_req.in_byte : 8'h00;
         if (pair) begin
            kanji_in = !cur_req.in_last;
         end else if (esc_leave) begin
            kanji_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         kanji_ff <= 1'b0;
         held_ff  <= 1'b0;
         lead_ff  <= 8'h00;
      end else begin
         kanji_ff <= kanji_in;
         held_ff  <= held_in;
         lead_ff  <= lead_in;
      end
   end

   `SJTIJ_ASSERT(held_is_lead_a, held_ff |-> is_lead(lead_ff), "held byte is not a lead byte")
   `SJTIJ_ASSERT(last_clears_a, (advance && cur_req.in_last) |=> (!kanji_ff && !held_ff),
                 "state not cleared after end of string")

endmodule

FILE: rtl/core/sjtij_serializer.sv
`timescale 1ns / 1ps
`include "shift_jis_to_iso2022_jp_top_defines.svh"
// ----------------------------------------------------------------------------
// sjtij_serializer
// holds one burst and sends its bytes one per cycle while rsp_ready is high
// ----------------------------------------------------------------------------
module sjtij_serializer (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 load,
   input  sjtij_pkg::burst_type burst,
   output logic                 can_load,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output sjtij_pkg::rsp_type   rsp_data
);
   import sjtij_pkg::*;

   logic [CountWidth-1:0]      count_ff;
   logic [CountWidth-1:0]      count_in;
   logic [IndexWidth-1:0]      index_ff;
   logic [IndexWidth-1:0]      index_in;
   logic [BurstDepth-1:0][7:0] bytes_ff;
   logic [BurstDepth-1:0][7:0] bytes_in;
   logic                       is_final;
   logic                       take;

   assign is_final  = (CountWidth'(index_ff) + CountWidth'(1)) == count_ff;
   assign rsp_valid = count_ff != '0;
   assign take      = rsp_valid && rsp_ready;
   assign can_load  = !rsp_valid || (take && is_final);

   assign rsp_data.out_byte = bytes_ff[index_ff];
   assign rsp_data.out_last = is_final;

   always_comb begin
      count_in = count_ff;
      index_in = index_ff;
      bytes_in = bytes_ff;
      if (take) begin
         if (is_final) begin
            count_in = '0;
         end
         index_in = index_ff + IndexWidth'(1);
      end
      if (load) begin
         count_in = burst.count;
         index_in = '0;
         bytes_in = burst.bytes;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         index_ff <= '0;
      end else begin
         count_ff <= count_in;
         index_ff <= index_in;
      end
   end

   always_ff @(posedge clock) begin
      bytes_ff <= bytes_in;
   end

   `SJTIJ_ASSERT(no_overwrite_a, load |-> can_load, "burst loaded over undelivered bytes")
   `SJTIJ_ASSERT(burst_continues_a, (take && !is_final) |=> rsp_valid,
                 "burst ended before its last byte")
   `SJTIJ_ASSERT_ALWAYS(index_in_range_a,
                        (count_ff != '0) |-> (CountWidth'(index_ff) < count_ff),
                        "read index beyond burst length")

endmodule
